// ----- hw/rtl/rcptm_pkg.sv -----
// Shared types, constants and a helper function for the tank drive mixer.
package rcptm_pkg;

    localparam int unsigned PULSE_W = 12;
    localparam int unsigned BAT_W   = 10;
    localparam int unsigned NUM_W   = 17;
    localparam int unsigned DEN_W   = 10;
    localparam int unsigned QUO_W   = 8;
    localparam int unsigned IDX_W   = 3;

    localparam logic [1:0] FAULT_OK    = 2'd0;
    localparam logic [1:0] FAULT_CFG   = 2'd1;
    localparam logic [1:0] FAULT_BAT   = 2'd2;
    localparam logic [1:0] FAULT_PULSE = 2'd3;

    localparam logic [IDX_W-1:0] REG_STEER_MIN       = 3'd0;
    localparam logic [IDX_W-1:0] REG_STEER_CENTER    = 3'd1;
    localparam logic [IDX_W-1:0] REG_STEER_MAX       = 3'd2;
    localparam logic [IDX_W-1:0] REG_THROTTLE_MIN    = 3'd3;
    localparam logic [IDX_W-1:0] REG_THROTTLE_CENTER = 3'd4;
    localparam logic [IDX_W-1:0] REG_THROTTLE_MAX    = 3'd5;

    localparam logic [PULSE_W-1:0] RST_STEER_MIN       = 12'd1105;
    localparam logic [PULSE_W-1:0] RST_STEER_CENTER    = 12'd1504;
    localparam logic [PULSE_W-1:0] RST_STEER_MAX       = 12'd1914;
    localparam logic [PULSE_W-1:0] RST_THROTTLE_MIN    = 12'd1120;
    localparam logic [PULSE_W-1:0] RST_THROTTLE_CENTER = 12'd1468;
    localparam logic [PULSE_W-1:0] RST_THROTTLE_MAX    = 12'd1930;

    localparam logic [PULSE_W-1:0] SPAN_MIN_US   = 12'd500;
    localparam logic [PULSE_W-1:0] SPAN_MAX_US   = 12'd2500;
    localparam logic [PULSE_W:0]   HALF_SPAN_CAP = 13'd501;
    localparam logic [BAT_W-1:0]   BAT_LOW       = 10'd620;
    localparam logic [BAT_W-1:0]   BAT_HIGH      = 10'd900;
    localparam logic [NUM_W-1:0]   BAT_NUM       = 17'd127500;
    localparam logic [6:0]         LIMIT_S8      = 7'd127;
    localparam logic [8:0]         DUTY_FULL     = 9'd255;
    localparam logic [8:0]         DUTY_DEADZONE = 9'd8;
    localparam logic [14:0]        ROUND_HALF    = 15'd64;

    typedef struct packed {
        logic [PULSE_W-1:0] steer_pulse;
        logic [PULSE_W-1:0] throttle_pulse;
        logic [PULSE_W-1:0] aux_pulse;
        logic [BAT_W-1:0]   battery_level;
    } frame_t;

    typedef struct packed {
        logic [7:0] left_duty;
        logic       left_ahead;
        logic [7:0] right_duty;
        logic       right_ahead;
        logic [1:0] fault_code;
    } result_t;

    typedef struct packed {
        logic [1:0] fault;
        logic       s_sat;
        logic       s_neg;
        logic       t_sat;
        logic       t_neg;
    } side_t;

    function automatic logic chan_ok(input logic [PULSE_W-1:0] lo,
                                     input logic [PULSE_W-1:0] mid,
                                     input logic [PULSE_W-1:0] hi);
        logic [PULSE_W:0] h_lo;
        logic [PULSE_W:0] h_hi;
        h_lo = 13'd1 + ((13'(mid - lo) + 13'd1) >> 1);
        h_hi = 13'd1 + ((13'(hi - mid) + 13'd1) >> 1);
        return (lo < mid) && (mid < hi) && (lo >= SPAN_MIN_US) && (hi <= SPAN_MAX_US)
            && (h_lo <= HALF_SPAN_CAP) && (h_hi <= HALF_SPAN_CAP);
    endfunction

endpackage

// ----- hw/rtl/rcptm_div.sv -----
// Pipelined restoring divider, two quotient bits per stage, four stages.
module rcptm_div
    import rcptm_pkg::*;
(
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    localparam int unsigned STAGES = QUO_W / 2;
    localparam int unsigned CMP_W  = NUM_W + 1;

    logic [NUM_W-1:0] rem_reg [STAGES];
    logic [DEN_W-1:0] den_reg [STAGES];
    logic [QUO_W-1:0] quo_reg [STAGES];

    logic [NUM_W-1:0] rem_next [STAGES];
    logic [QUO_W-1:0] quo_next [STAGES];

    always_comb
    begin
        logic [NUM_W-1:0] r;
        logic [QUO_W-1:0] q;
        logic [CMP_W-1:0] sub;
        for (int k = 0; k < STAGES; k++)
        begin
            r = (k == 0) ? num : rem_reg[k-1];
            q = (k == 0) ? '0 : quo_reg[k-1];
            for (int j = 0; j < 2; j++)
            begin
                sub = CMP_W'((k == 0) ? den : den_reg[k-1]) << (QUO_W - 1 - 2 * k - j);
                if (CMP_W'(r) >= sub)
                begin
                    r = NUM_W'(CMP_W'(r) - sub);
                    q[QUO_W - 1 - 2 * k - j] = 1'b1;
                end
            end
            rem_next[k] = r;
            quo_next[k] = q;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            rem_reg[k] <= rem_next[k];
            quo_reg[k] <= quo_next[k];
            den_reg[k] <= (k == 0) ? den : den_reg[k-1];
        end
    end

    assign quo = quo_reg[STAGES-1];

endmodule

// ----- hw/rtl/rc_pulse_tank_drive_mixer.sv -----
// Top level of the differential tank drive mixer pipeline.
// Usage:
//   Drive a frame (steering, throttle, aux pulse widths and battery level)
//   on frame and raise start for one cycle; busy stays low, so a frame may
//   be taken at every clock edge.
//   Each frame yields one result beat on result, marked by done for exactly
//   one cycle. done rises once the frame has passed the setup register, the
//   four divider stages, the mix register and the output register. Results
//   leave in the order the frames came in.
//   Throughput is one frame per cycle: the three quotients (steering,
//   throttle, battery ceiling) run in parallel four-stage dividers, and
//   every stage advances each cycle.
//   The user must write timing registers via wr_en, wr_idx and wr_data
//   while no frame is in flight (unenforced); indexes 6 and 7 are dropped.
//   Reset clears all valid bits and loads the default channel timings.
//   The receiver cannot stall; a result is present for its one cycle only.
module rc_pulse_tank_drive_mixer
    import rcptm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  frame_t             frame,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_idx,
    input  logic [PULSE_W-1:0] wr_data,
    output logic               done,
    output result_t            result
);

    localparam int unsigned DIV_STAGES = QUO_W / 2;

    logic [PULSE_W-1:0] steer_min_reg, steer_center_reg, steer_max_reg;
    logic [PULSE_W-1:0] throttle_min_reg, throttle_center_reg, throttle_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steer_min_reg       <= RST_STEER_MIN;
            steer_center_reg    <= RST_STEER_CENTER;
            steer_max_reg       <= RST_STEER_MAX;
            throttle_min_reg    <= RST_THROTTLE_MIN;
            throttle_center_reg <= RST_THROTTLE_CENTER;
            throttle_max_reg    <= RST_THROTTLE_MAX;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                REG_STEER_MIN:       steer_min_reg       <= wr_data;
                REG_STEER_CENTER:    steer_center_reg    <= wr_data;
                REG_STEER_MAX:       steer_max_reg       <= wr_data;
                REG_THROTTLE_MIN:    throttle_min_reg    <= wr_data;
                REG_THROTTLE_CENTER: throttle_center_reg <= wr_data;
                REG_THROTTLE_MAX:    throttle_max_reg    <= wr_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // input stage
    logic   in_vld_reg;
    frame_t in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        in_reg <= frame;
    end

    // numerator, divisor and fault setup
    logic               cfg_ok;
    logic               s_lt, t_lt;
    logic [PULSE_W-1:0] s_d, t_d, s_span, t_span;
    logic [PULSE_W:0]   s_h, t_h;
    side_t              side_next;
    logic [NUM_W-1:0]   s_num_next, t_num_next, b_num_next;
    logic [DEN_W-1:0]   s_den_next, t_den_next;

    always_comb
    begin
        cfg_ok = chan_ok(steer_min_reg, steer_center_reg, steer_max_reg)
              && chan_ok(throttle_min_reg, throttle_center_reg, throttle_max_reg);
        s_lt   = in_reg.steer_pulse < steer_center_reg;
        t_lt   = in_reg.throttle_pulse < throttle_center_reg;
        s_d    = s_lt ? steer_center_reg - in_reg.steer_pulse
                      : in_reg.steer_pulse - steer_center_reg;
        t_d    = t_lt ? throttle_center_reg - in_reg.throttle_pulse
                      : in_reg.throttle_pulse - throttle_center_reg;
        s_span = s_lt ? steer_center_reg - steer_min_reg : steer_max_reg - steer_center_reg;
        t_span = t_lt ? throttle_center_reg - throttle_min_reg
                      : throttle_max_reg - throttle_center_reg;
        s_h    = 13'd1 + ((13'(s_span) + 13'd1) >> 1);
        t_h    = 13'd1 + ((13'(t_span) + 13'd1) >> 1);
        s_num_next = NUM_W'({s_d[9:0], 6'b0}) + NUM_W'(s_h[DEN_W-1:1]);
        t_num_next = NUM_W'({t_d[9:0], 6'b0}) + NUM_W'(t_h[DEN_W-1:1]);
        s_den_next = s_h[DEN_W-1:0];
        t_den_next = t_h[DEN_W-1:0];
        b_num_next = BAT_NUM + NUM_W'(in_reg.battery_level >> 1);

        side_next.s_neg = s_lt;
        side_next.t_neg = t_lt;
        side_next.s_sat = (in_reg.steer_pulse <= steer_min_reg)
                       || (in_reg.steer_pulse >= steer_max_reg);
        side_next.t_sat = (in_reg.throttle_pulse <= throttle_min_reg)
                       || (in_reg.throttle_pulse >= throttle_max_reg);
        if (!cfg_ok)
            side_next.fault = FAULT_CFG;
        else if (in_reg.battery_level <= BAT_LOW || in_reg.battery_level >= BAT_HIGH)
            side_next.fault = FAULT_BAT;
        else if (in_reg.steer_pulse == '0 || in_reg.throttle_pulse == '0
                 || in_reg.aux_pulse == '0)
            side_next.fault = FAULT_PULSE;
        else
            side_next.fault = FAULT_OK;
    end

    logic             setup_vld_reg;
    side_t            setup_side_reg;
    logic [NUM_W-1:0] s_num_reg, t_num_reg, b_num_reg;
    logic [DEN_W-1:0] s_den_reg, t_den_reg, b_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            setup_vld_reg <= 1'b0;
        else
            setup_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        setup_side_reg <= side_next;
        s_num_reg      <= s_num_next;
        t_num_reg      <= t_num_next;
        b_num_reg      <= b_num_next;
        s_den_reg      <= s_den_next;
        t_den_reg      <= t_den_next;
        b_den_reg      <= in_reg.battery_level;
    end

    // dividers
    logic [QUO_W-1:0] s_quo, t_quo, b_quo;

    rcptm_div u_div_steer (.clk(clk), .num(s_num_reg), .den(s_den_reg), .quo(s_quo));
    rcptm_div u_div_throttle (.clk(clk), .num(t_num_reg), .den(t_den_reg), .quo(t_quo));
    rcptm_div u_div_battery (.clk(clk), .num(b_num_reg), .den(b_den_reg), .quo(b_quo));

    logic  dv_vld_reg  [DIV_STAGES];
    side_t dv_side_reg [DIV_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
                dv_vld_reg[k] <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < DIV_STAGES; k++)
                dv_vld_reg[k] <= (k == 0) ? setup_vld_reg : dv_vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STAGES; k++)
            dv_side_reg[k] <= (k == 0) ? setup_side_reg : dv_side_reg[k-1];
    end

    // mix stage
    side_t       dv_side;
    logic [6:0]  s_mag, t_mag, as_mag, at_mag;
    logic [8:0]  at_s, as_s, l_sum, r_sum;
    logic [7:0]  l_next, r_next;

    function automatic logic [7:0] clamp_s8(input logic [8:0] v);
        if ($signed(v) > $signed({2'b00, LIMIT_S8}))
            return {1'b0, LIMIT_S8};
        else if ($signed(v) < -$signed({2'b00, LIMIT_S8}))
            return -{1'b0, LIMIT_S8};
        else
            return v[7:0];
    endfunction

    always_comb
    begin
        dv_side = dv_side_reg[DIV_STAGES-1];
        s_mag   = (dv_side.s_sat || s_quo > QUO_W'(LIMIT_S8)) ? LIMIT_S8 : s_quo[6:0];
        t_mag   = (dv_side.t_sat || t_quo > QUO_W'(LIMIT_S8)) ? LIMIT_S8 : t_quo[6:0];
        at_mag  = dv_side.t_neg ? 7'((8'(t_mag) + 8'd1) >> 1) : t_mag;
        as_mag  = 7'((8'(s_mag) + 8'd1) >> 1);
        at_s    = dv_side.t_neg ? -9'(at_mag) : 9'(at_mag);
        as_s    = dv_side.s_neg ? -9'(as_mag) : 9'(as_mag);
        l_sum   = at_s + as_s;
        r_sum   = at_s - as_s;
        l_next  = clamp_s8(l_sum);
        r_next  = clamp_s8(r_sum);
    end

    logic             mix_vld_reg;
    logic [1:0]       mix_fault_reg;
    logic [7:0]       mix_l_reg, mix_r_reg;
    logic [QUO_W-1:0] mix_ceil_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mix_vld_reg <= 1'b0;
        else
            mix_vld_reg <= dv_vld_reg[DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        mix_fault_reg <= dv_side.fault;
        mix_l_reg     <= l_next;
        mix_r_reg     <= r_next;
        mix_ceil_reg  <= b_quo;
    end

    // duty scaling
    function automatic logic [7:0] duty_of(input logic [7:0] m, input logic [7:0] ceil_v);
        logic [6:0]  mag;
        logic [14:0] prod;
        logic [8:0]  d;
        mag  = m[7] ? 7'(-m) : m[6:0];
        prod = 15'(mag) * 15'(ceil_v);
        d    = 9'd1 + 9'((prod + ROUND_HALF) >> 7);
        if (d > DUTY_FULL)
            d = DUTY_FULL;
        if (d < DUTY_DEADZONE || m == '0)
            d = '0;
        return d[7:0];
    endfunction

    result_t res_next;

    always_comb
    begin
        res_next = '0;
        res_next.fault_code = mix_fault_reg;
        if (mix_fault_reg == FAULT_OK)
        begin
            res_next.left_duty   = duty_of(mix_l_reg, mix_ceil_reg);
            res_next.right_duty  = duty_of(mix_r_reg, mix_ceil_reg);
            res_next.left_ahead  = !mix_l_reg[7] && mix_l_reg != '0;
            res_next.right_ahead = !mix_r_reg[7] && mix_r_reg != '0;
        end
    end

    logic    done_reg;
    result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= mix_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_fault_clears: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.fault_code != FAULT_OK |->
            result.left_duty == '0 && result.right_duty == '0
            && !result.left_ahead && !result.right_ahead)
        else $error("faulted beat carries drive");

    a_dead_zone: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.left_duty != '0 || result.right_duty != '0) |->
            (result.left_duty == '0 || result.left_duty >= 8'(DUTY_DEADZONE))
            && (result.right_duty == '0 || result.right_duty >= 8'(DUTY_DEADZONE)))
        else $error("duty inside dead zone");

    a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(mix_vld_reg))
        else $error("result beat without a frame in flight");

endmodule
